// ===== src/pvq_pkg.sv =====
// ----------------------------------------------------------------------------
// pvq_pkg: shared types and codes for the priority voice queue
// Request and result structs, operation codes and the stored slot layout.
// ----------------------------------------------------------------------------
package pvq_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // one request
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] priority_req;
        logic [15:0]        handle;
        logic               handle_active;
    } t_req;

    // one result
    typedef struct packed {
        logic        evicted_valid;
        logic [15:0] evicted_handle;
        logic        removed;
        logic [4:0]  entry_count;
    } t_res;

    // one stored queue entry
    typedef struct packed {
        logic [15:0]        handle;
        logic signed [15:0] prio;
    } t_slot;

endpackage

// ===== src/priority_voice_queue.sv =====
// ----------------------------------------------------------------------------
// priority_voice_queue: bounded sorted queue of sound handles
// Entries live in one single-port-read, single-port-write memory used as a
// ring; a sequencer shifts entries one per cycle to insert or remove.
// ----------------------------------------------------------------------------
// Usage: raise start with a request while busy is low. Clear, an unused
// operation code, and a remove of an inactive handle or from an empty queue
// finish in the accept cycle. An insert reads from the back and moves each
// entry of higher priority up one place, then writes the new entry; into an
// empty queue it writes directly, and a full queue first evicts its front
// entry. A remove walks the whole occupied part of the queue. The memory
// reads one entry and writes one entry per cycle. The result shows on o_res
// for exactly one cycle with o_res_valid, the cycle after the sequencer
// finishes; a new request may be accepted in that same cycle, and the
// receiver cannot hold results off.
module priority_voice_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  pvq_pkg::t_req i_req,
    output logic          busy,
    output logic          o_res_valid,
    output pvq_pkg::t_res o_res
);
    import pvq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EV_WAIT   = 3'd1;
    localparam logic [2:0] S_INS_BEGIN = 3'd2;
    localparam logic [2:0] S_INS_SCAN  = 3'd3;
    localparam logic [2:0] S_INS_PUT   = 3'd4;
    localparam logic [2:0] S_REM_SCAN  = 3'd5;

    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    // logical position (from the front) to ring address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // registers
    logic [2:0]    r_state, n_state;
    t_req          r_req, n_req;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_dval, n_dval;
    logic          r_found, n_found;
    logic          r_ev_valid, n_ev_valid;
    logic [15:0]   r_ev_handle, n_ev_handle;
    logic          r_out_valid, n_out_valid;
    t_res          r_out, n_out;

    // memory port signals
    t_slot         mem [QUEUE_DEPTH];
    t_slot         r_rd_data;
    logic          rd_en;
    logic [CW-1:0] rd_idx;
    logic          wr_en;
    logic [CW-1:0] wr_idx;
    t_slot         wr_data;
    t_slot         new_slot;
    logic [CW-1:0] d_idx;
    logic          hit;

    assign new_slot.handle = r_req.handle;
    assign new_slot.prio   = r_req.priority_req;
    assign d_idx           = r_idx - 1'b1;
    assign hit             = (r_rd_data.handle == r_req.handle);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_dval      = 1'b0;
        n_found     = r_found;
        n_ev_valid  = r_ev_valid;
        n_ev_handle = r_ev_handle;
        n_out_valid = 1'b0;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_idx      = '0;
        wr_en       = 1'b0;
        wr_idx      = '0;
        wr_data     = new_slot;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_out.evicted_valid  = 1'b0;
                    n_out.evicted_handle = '0;
                    n_out.removed        = 1'b0;
                    n_out.entry_count    = 5'(r_count);
                    case (i_req.operation)
                        OP_INSERT: begin
                            n_ev_valid  = 1'b0;
                            n_ev_handle = '0;
                            if (r_count == FULL) begin
                                // fetch the front entry to evict
                                rd_en   = 1'b1;
                                rd_idx  = '0;
                                n_state = S_EV_WAIT;
                            end else begin
                                n_state = S_INS_BEGIN;
                            end
                        end
                        OP_REMOVE: begin
                            if (i_req.handle_active && (r_count != '0)) begin
                                n_idx   = '0;
                                n_found = 1'b0;
                                n_state = S_REM_SCAN;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count           = '0;
                            n_out.entry_count = '0;
                            n_out_valid       = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_EV_WAIT: begin
                // drop the front by moving the ring head
                n_ev_valid  = 1'b1;
                n_ev_handle = r_rd_data.handle;
                n_head      = phys(r_head, CW'(1));
                n_count     = r_count - 1'b1;
                n_state     = S_INS_BEGIN;
            end

            S_INS_BEGIN: begin
                if (r_count == '0) begin
                    wr_en   = 1'b1;
                    wr_idx  = '0;
                    n_state = S_IDLE;
                    n_count = r_count + 1'b1;
                    n_out_valid = 1'b1;
                    n_out = '{r_ev_valid, r_ev_handle, 1'b0, 5'(r_count + 1'b1)};
                end else begin
                    rd_en   = 1'b1;
                    rd_idx  = r_count - 1'b1;
                    n_idx   = r_count - 1'b1;
                    n_state = S_INS_SCAN;
                end
            end

            S_INS_SCAN: begin
                // walk from the back, moving higher priorities up one place
                wr_en  = 1'b1;
                wr_idx = r_idx + 1'b1;
                if (r_rd_data.prio > r_req.priority_req) begin
                    wr_data = r_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        rd_en  = 1'b1;
                        rd_idx = r_idx - 1'b1;
                        n_idx  = r_idx - 1'b1;
                    end
                end else begin
                    n_state = S_IDLE;
                    n_count = r_count + 1'b1;
                    n_out_valid = 1'b1;
                    n_out = '{r_ev_valid, r_ev_handle, 1'b0, 5'(r_count + 1'b1)};
                end
            end

            S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_idx  = '0;
                n_state = S_IDLE;
                n_count = r_count + 1'b1;
                n_out_valid = 1'b1;
                n_out = '{r_ev_valid, r_ev_handle, 1'b0, 5'(r_count + 1'b1)};
            end

            S_REM_SCAN: begin
                // stream reads front to back; after the match, move each one down
                if (r_idx < r_count) begin
                    rd_en  = 1'b1;
                    rd_idx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end
                n_dval = rd_en;
                if (r_dval) begin
                    if (r_found) begin
                        wr_en   = 1'b1;
                        wr_idx  = d_idx - 1'b1;
                        wr_data = r_rd_data;
                    end else if (hit) begin
                        n_found = 1'b1;
                    end
                    if (r_idx == r_count) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        if (r_found || hit) begin
                            n_count = r_count - 1'b1;
                            n_out   = '{1'b0, 16'd0, 1'b1, 5'(r_count - 1'b1)};
                        end else begin
                            n_out   = '{1'b0, 16'd0, 1'b0, 5'(r_count)};
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_dval      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_dval      <= n_dval;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_ev_valid  <= n_ev_valid;
        r_ev_handle <= n_ev_handle;
        r_out       <= n_out;
    end

    // slot memory, read data registered
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[phys(r_head, wr_idx)] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[phys(r_head, rd_idx)];
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== src/pvq_checker.sv =====
// ----------------------------------------------------------------------------
// pvq_checker: port-level checks for the priority voice queue
// Watches requests and results on the top-level ports only.
// ----------------------------------------------------------------------------
module pvq_checker #(
    parameter int DEPTH = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input pvq_pkg::t_req i_req,
    input logic          busy,
    input logic          o_res_valid,
    input pvq_pkg::t_res o_res
);
    import pvq_pkg::*;

    // a result only follows an accepted request or work in progress
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy || start))
        else $error("result without a request");

    // a clear answers at once with an empty queue
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.operation == OP_CLEAR)
            |=> (o_res_valid && o_res.entry_count == 5'd0))
        else $error("clear did not report an empty queue");

    // eviction and removal never flag together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res.evicted_valid && o_res.removed))
        else $error("evict and remove both flagged");

    // the count never exceeds the depth (checked only for depths up to 31)
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ((DEPTH > 31) || (32'(o_res.entry_count) <= DEPTH)))
        else $error("entry count beyond depth");

    // a non-insert request reports no eviction
    a_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.operation != OP_INSERT)
            |=> (!o_res_valid || !o_res.evicted_valid))
        else $error("eviction reported for a non-insert request");

endmodule

bind priority_voice_queue pvq_checker #(.DEPTH(QUEUE_DEPTH)) u_pvq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .i_req       (i_req),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// ===== tb/tb_priority_voice_queue.sv =====
// ----------------------------------------------------------------------------
// tb_priority_voice_queue: self-checking bench for the priority voice queue
// Drives insert, remove, clear and unused-code requests through the
// start/busy handshake, predicts every result with a local copy of the sorted
// queue and compares each strobed result field by field, in order.
// ----------------------------------------------------------------------------
module tb_priority_voice_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import pvq_pkg::*;

    localparam int         QDEPTH         = 16;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         RANDOM_ITEMS   = 600;
    localparam int         CALM_TAIL      = 100;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         REPORT_LIMIT   = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: sorted queue predictor plus the list of pending results
    // ------------------------------------------------------------------------
    class pvq_scoreboard;
        t_slot held [QDEPTH];
        int    fill;
        t_res  expected_q [$];
        int    mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // close the gap left at pos
        function void drop_entry(int pos);
            int i;
            for (i = pos; i + 1 < fill; i++) begin
                held[i] = held[i + 1];
            end
            fill--;
        endfunction

        // work out the result of one accepted request and queue it
        function void note_request(t_req r);
            t_res res;
            int   pos;
            int   i;
            res = '0;
            case (r.operation)
                OP_INSERT: begin
                    // full list: the front entry goes first
                    if (fill >= QDEPTH) begin
                        res.evicted_valid  = 1'b1;
                        res.evicted_handle = held[0].handle;
                        drop_entry(0);
                    end
                    // land after every entry of lower or equal priority
                    pos = 0;
                    while (pos < fill && $signed(held[pos].prio) <= $signed(r.priority_req))
                        pos++;
                    for (i = fill; i > pos; i--) begin
                        held[i] = held[i - 1];
                    end
                    held[pos].handle = r.handle;
                    held[pos].prio   = r.priority_req;
                    fill++;
                end
                OP_REMOVE: begin
                    // only the frontmost match, and only for a playing handle
                    if (r.handle_active) begin
                        for (i = 0; i < fill; i++) begin
                            if (held[i].handle == r.handle) begin
                                drop_entry(i);
                                res.removed = 1'b1;
                                break;
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    fill = 0;
                end
                default: begin
                end
            endcase
            res.entry_count = 5'(fill);
            expected_q.push_back(res);
        endfunction

        // compare one strobed result with the oldest expectation
        function void check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with no request pending: %p", $time, got);
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.evicted_valid  !== want.evicted_valid  ||
                got.evicted_handle !== want.evicted_handle ||
                got.removed        !== want.removed        ||
                got.entry_count    !== want.entry_count) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: mismatch: exp ev=%b/%h rm=%b cnt=%0d,",
                              " got ev=%b/%h rm=%b cnt=%0d"},
                             $time, want.evicted_valid, want.evicted_handle, want.removed,
                             want.entry_count, got.evicted_valid, got.evicted_handle,
                             got.removed, got.entry_count);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int entries();
            return fill;
        endfunction

        function logic [15:0] handle_at(int idx);
            return held[idx].handle;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and clock
    // ------------------------------------------------------------------------
    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    t_req          i_req   = '0;
    logic          busy;
    logic          o_res_valid;
    t_res          o_res;

    pvq_scoreboard sb = new();
    int            gap_odds = 0;
    int            stall_cycles = 0;

    priority_voice_queue #(
        .QUEUE_DEPTH(QDEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // results cannot be held off: take each one at the edge ending its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid === 1'b1)
            sb.check_result(o_res);
    end

    // watchdog: too long without a request or a result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_res_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request drivers
    // ------------------------------------------------------------------------
    // present a request and hold it until an edge sees busy low
    task automatic issue(input t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // one request, then a random gap while gaps are enabled
    task automatic request(input logic [1:0] op, input logic signed [15:0] prio,
                           input logic [15:0] hnd, input logic act);
        t_req r;
        r.operation     = op;
        r.priority_req  = prio;
        r.handle        = hnd;
        r.handle_active = act;
        issue(r);
        if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0)
            pause($urandom_range(1, 13));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int                 i;
        int                 roll;
        logic [1:0]         op;
        logic signed [15:0] prio;
        logic [15:0]        hnd;
        logic               act;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list corners, field extremes, ties and duplicates
        gap_odds = 3;
        request(OP_CLEAR,  16'sd0, 16'h0000, 1'b0);
        request(OP_REMOVE, 16'sd0, 16'h0000, 1'b1);
        request(OP_UNUSED, -16'sd1, 16'hFFFF, 1'b1);
        request(OP_INSERT, -16'sd32768, 16'h0000, 1'b0);
        request(OP_INSERT, 16'sd32767, 16'hFFFF, 1'b1);
        request(OP_INSERT, 16'sd0, 16'h1234, 1'b0);
        request(OP_INSERT, 16'sd0, 16'h5678, 1'b0);
        request(OP_INSERT, 16'sd0, 16'h1234, 1'b0);
        request(OP_REMOVE, 16'sd0, 16'h1234, 1'b0);
        request(OP_REMOVE, 16'sd0, 16'hBEEF, 1'b1);
        request(OP_REMOVE, 16'sd0, 16'h1234, 1'b1);
        // fill to capacity, then one insert that evicts the front entry
        for (i = 0; i < 13; i++) begin
            request(OP_INSERT, 16'(i * 1000 - 6000), 16'(16'h0100 + i), 1'b0);
        end
        request(OP_CLEAR, 16'sd0, 16'h0000, 1'b1);

        // random: mostly inserts and hits on held handles, so the list fills
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - CALM_TAIL)
                gap_odds = 0;
            else if (i % 40 == 0)
                gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 5);

            roll = $urandom_range(0, 99);
            if (roll < 55)      op = OP_INSERT;
            else if (roll < 93) op = OP_REMOVE;
            else if (roll < 97) op = OP_CLEAR;
            else                op = OP_UNUSED;

            prio = ($urandom_range(0, 1) == 0) ? 16'(int'($urandom_range(0, 8)) - 4)
                                               : 16'($urandom);
            hnd  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
            if (op == OP_REMOVE && sb.entries() > 0 && $urandom_range(0, 3) != 0)
                hnd = sb.handle_at($urandom_range(0, sb.entries() - 1));
            act  = ($urandom_range(0, 9) != 0);

            request(op, prio, hnd, act);
        end
        start <= 1'b0;

        // let every outstanding result arrive, then allow for late strays
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pvq_pkg.sv
src/priority_voice_queue.sv
src/pvq_checker.sv
tb/tb_priority_voice_queue.sv
